[sv/fifo_reader_writer_lock_defines.svh]
// assertion macros for the fifo reader/writer lock checker
// depends on nothing; expects clk and rst_n in the scope where it is used
`ifndef FIFO_READER_WRITER_LOCK_DEFINES_SVH
`define FIFO_READER_WRITER_LOCK_DEFINES_SVH

// same-cycle implication, quiet during reset
`define FRWL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frwl check failed");

// next-cycle implication, quiet during reset
`define FRWL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frwl check failed");

`endif

[sv/frwl_pkg.sv]
// shared types, codes and helpers for the fifo reader/writer lock
// depends on nothing
package frwl_pkg;

    localparam int OP_W    = 2;
    localparam int TAG_W   = 8;
    localparam int MEM_W   = 3;
    localparam int MODE_W  = 2;
    localparam int EV_W    = 3;
    localparam int COUNT_W = 16;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_CANCEL  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_READ = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RW   = 2'd1;

    localparam logic [EV_W-1:0] EV_GRANTED   = 3'd0;
    localparam logic [EV_W-1:0] EV_QUEUED    = 3'd1;
    localparam logic [EV_W-1:0] EV_RELEASED  = 3'd2;
    localparam logic [EV_W-1:0] EV_CANCELLED = 3'd3;
    localparam logic [EV_W-1:0] EV_NOT_FOUND = 3'd4;
    localparam logic [EV_W-1:0] EV_FULL      = 3'd5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [MEM_W-1:0]  mem;
        logic [MODE_W-1:0] mode;
    } entry_t;

    typedef struct packed {
        logic [COUNT_W-1:0] reader_count;
        logic [COUNT_W-1:0] writer_count;
        logic [MEM_W-1:0]   write_owner;
    } lock_state_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

    function automatic logic [COUNT_W-1:0] clamp_dec(input logic [COUNT_W-1:0] v);
        return (v == '0) ? v : v - COUNT_W'(1);
    endfunction

endpackage

[sv/frwl_qmem.sv]
// wait queue storage: one write port, one registered read port
// depends on frwl_pkg for the entry type
module frwl_qmem #(
    parameter int DEPTH = frwl_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  frwl_pkg::entry_t                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output frwl_pkg::entry_t                        rd_data
);

    frwl_pkg::entry_t queue_mem [DEPTH];
    frwl_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            queue_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= queue_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/frwl_grant.sv]
// grant check: decides whether a mode can be granted and gives the updated lock state
// depends on frwl_pkg
module frwl_grant (
    input  frwl_pkg::lock_state_t               cur,
    input  logic [frwl_pkg::MEM_W-1:0]          mem_id,
    input  logic [frwl_pkg::MODE_W-1:0]         mode,
    output logic                                ok,
    output frwl_pkg::lock_state_t               nxt
);

    always_comb
    begin
        nxt = cur;
        ok  = 1'b0;
        case (mode)
            frwl_pkg::MODE_READ:
            begin
                if (cur.writer_count == '0)
                begin
                    ok = 1'b1;
                    nxt.reader_count = frwl_pkg::sat_inc(cur.reader_count);
                end
            end
            frwl_pkg::MODE_RW:
            begin
                if (cur.reader_count == '0 && cur.writer_count == '0)
                begin
                    ok = 1'b1;
                    nxt.write_owner  = mem_id;
                    nxt.reader_count = frwl_pkg::sat_inc(cur.reader_count);
                    nxt.writer_count = frwl_pkg::sat_inc(cur.writer_count);
                end
            end
            default:
            begin
                // write, and the unused mode code acts as write
                if (cur.reader_count == '0
                    && (cur.writer_count == '0 || cur.write_owner == mem_id))
                begin
                    ok = 1'b1;
                    nxt.write_owner  = mem_id;
                    nxt.writer_count = frwl_pkg::sat_inc(cur.writer_count);
                end
            end
        endcase
    end

endmodule

[sv/fifo_reader_writer_lock.sv]
// Reader/writer lock with a FIFO wait queue.
// Command channel (cmd_valid/cmd_stall): op, requester_tag, mem_sel, access_mode.
// Result channel (res_valid/res_stall): result_tag, event_res, last.
// A command transfers when cmd_valid is high and cmd_stall low; the block takes one
// command at a time and holds cmd_stall high until the last result is registered.
// Steps per command, as the sequencer walks the queue memory one port at a time:
//   acquire  S_ACQ, then S_FIN
//   release  S_REL, S_HEAD per waiter granted and for a blocked waiter at the head, then S_FIN
//   cancel   S_SRCH_RD and S_SRCH_CMP per entry searched, then S_SH_RD and S_SH_WR
//            per entry moved up to close the gap, then S_FIN
//   unknown op  no result
// A release gives "release done" and then one "granted" per queue head granted;
// last marks the final result of each command.
// If res_stall is high the result register holds and the sequencer waits on it.
// Reset clears the counts, the queue head and fill and the result valid flag; queue entries
// are not cleared, only those below the fill are read.
module fifo_reader_writer_lock #(
    parameter int QUEUE_DEPTH = frwl_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  logic [frwl_pkg::OP_W-1:0]       op,
    input  logic [frwl_pkg::TAG_W-1:0]      requester_tag,
    input  logic [frwl_pkg::MEM_W-1:0]      mem_sel,
    input  logic [frwl_pkg::MODE_W-1:0]     access_mode,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic [frwl_pkg::TAG_W-1:0]      result_tag,
    output logic [frwl_pkg::EV_W-1:0]       event_res,
    output logic                            last
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_A = (AW+1)'(QUEUE_DEPTH);
    localparam logic [FW-1:0] DEPTH_F = FW'(QUEUE_DEPTH);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ACQ      = 4'd1;
    localparam logic [3:0] S_REL      = 4'd2;
    localparam logic [3:0] S_HEAD     = 4'd3;
    localparam logic [3:0] S_SRCH_RD  = 4'd4;
    localparam logic [3:0] S_SRCH_CMP = 4'd5;
    localparam logic [3:0] S_SH_RD    = 4'd6;
    localparam logic [3:0] S_SH_WR    = 4'd7;
    localparam logic [3:0] S_FIN      = 4'd8;

    function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] head,
                                                input logic [AW-1:0] lidx);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, lidx};
        if (s >= DEPTH_A)
        begin
            s = s - DEPTH_A;
        end
        return s[AW-1:0];
    endfunction

    logic [3:0]                     state_reg, state_next;
    frwl_pkg::lock_state_t          lock_reg, lock_next;
    logic [AW-1:0]                  head_reg, head_next;
    logic [FW-1:0]                  fill_reg, fill_next;
    logic [FW-1:0]                  idx_reg, idx_next;
    logic [frwl_pkg::TAG_W-1:0]     cmd_tag_reg, cmd_tag_next;
    logic [frwl_pkg::MEM_W-1:0]     cmd_mem_reg, cmd_mem_next;
    logic [frwl_pkg::MODE_W-1:0]    cmd_mode_reg, cmd_mode_next;
    logic [frwl_pkg::TAG_W-1:0]     pend_tag_reg, pend_tag_next;
    logic [frwl_pkg::EV_W-1:0]      pend_ev_reg, pend_ev_next;
    logic                           res_valid_reg, res_valid_next;
    logic [frwl_pkg::TAG_W-1:0]     res_tag_reg, res_tag_next;
    logic [frwl_pkg::EV_W-1:0]      res_ev_reg, res_ev_next;
    logic                           res_last_reg, res_last_next;

    logic                           out_free;
    logic [AW-1:0]                  head_inc;
    logic [FW-1:0]                  idx_plus;
    logic                           rd_en;
    logic [AW-1:0]                  rd_lidx;
    logic                           wr_en;
    logic [AW-1:0]                  wr_lidx;
    frwl_pkg::entry_t               wr_data;
    frwl_pkg::entry_t               rd_data;
    logic [frwl_pkg::MEM_W-1:0]     g_mem;
    logic [frwl_pkg::MODE_W-1:0]    g_mode;
    logic                           g_ok;
    frwl_pkg::lock_state_t          g_nxt;

    frwl_qmem #(
        .DEPTH (QUEUE_DEPTH)
    ) u_qmem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (phys_addr(head_reg, wr_lidx)),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (phys_addr(head_reg, rd_lidx)),
        .rd_data (rd_data)
    );

    // the queue head is checked from memory, everything else from the latched command
    assign g_mem  = (state_reg == S_HEAD) ? rd_data.mem  : cmd_mem_reg;
    assign g_mode = (state_reg == S_HEAD) ? rd_data.mode : cmd_mode_reg;

    frwl_grant u_grant (
        .cur    (lock_reg),
        .mem_id (g_mem),
        .mode   (g_mode),
        .ok     (g_ok),
        .nxt    (g_nxt)
    );

    assign out_free = !res_valid_reg || !res_stall;
    assign head_inc = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign idx_plus = idx_reg + FW'(1);
    // a gap close moves the entry just read, otherwise the latched command is queued
    assign wr_data  = (state_reg == S_SH_WR) ? rd_data
                    : frwl_pkg::entry_t'{tag: cmd_tag_reg, mem: cmd_mem_reg,
                                         mode: cmd_mode_reg};

    always_comb
    begin
        state_next     = state_reg;
        lock_next      = lock_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        cmd_tag_next   = cmd_tag_reg;
        cmd_mem_next   = cmd_mem_reg;
        cmd_mode_next  = cmd_mode_reg;
        pend_tag_next  = pend_tag_reg;
        pend_ev_next   = pend_ev_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_tag_next   = res_tag_reg;
        res_ev_next    = res_ev_reg;
        res_last_next  = res_last_reg;
        rd_en          = 1'b0;
        rd_lidx        = '0;
        wr_en          = 1'b0;
        wr_lidx        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_tag_next  = requester_tag;
                    cmd_mem_next  = mem_sel;
                    cmd_mode_next = access_mode;
                    idx_next      = '0;
                    case (op)
                        frwl_pkg::OP_ACQUIRE: state_next = S_ACQ;
                        frwl_pkg::OP_RELEASE: state_next = S_REL;
                        frwl_pkg::OP_CANCEL:  state_next = S_SRCH_RD;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_ACQ:
            begin
                pend_tag_next = cmd_tag_reg;
                if (fill_reg == '0 && g_ok)
                begin
                    lock_next    = g_nxt;
                    pend_ev_next = frwl_pkg::EV_GRANTED;
                end
                else if (fill_reg < DEPTH_F)
                begin
                    wr_en        = 1'b1;
                    wr_lidx      = fill_reg[AW-1:0];
                    fill_next    = fill_reg + FW'(1);
                    pend_ev_next = frwl_pkg::EV_QUEUED;
                end
                else
                begin
                    pend_ev_next = frwl_pkg::EV_FULL;
                end
                state_next = S_FIN;
            end
            S_REL:
            begin
                case (cmd_mode_reg)
                    frwl_pkg::MODE_READ:
                    begin
                        lock_next.reader_count = frwl_pkg::clamp_dec(lock_reg.reader_count);
                    end
                    frwl_pkg::MODE_RW:
                    begin
                        lock_next.reader_count = frwl_pkg::clamp_dec(lock_reg.reader_count);
                        lock_next.writer_count = frwl_pkg::clamp_dec(lock_reg.writer_count);
                    end
                    default:
                    begin
                        lock_next.writer_count = frwl_pkg::clamp_dec(lock_reg.writer_count);
                    end
                endcase
                pend_tag_next = cmd_tag_reg;
                pend_ev_next  = frwl_pkg::EV_RELEASED;
                if (fill_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_lidx    = '0;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                // the held result goes out as not-last only once another grant follows
                if (!g_ok)
                begin
                    state_next = S_FIN;
                end
                else if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_tag_next   = pend_tag_reg;
                    res_ev_next    = pend_ev_reg;
                    res_last_next  = 1'b0;
                    lock_next      = g_nxt;
                    pend_tag_next  = rd_data.tag;
                    pend_ev_next   = frwl_pkg::EV_GRANTED;
                    head_next      = head_inc;
                    fill_next      = fill_reg - FW'(1);
                    if (fill_reg == FW'(1))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        // next head sits one past the current head
                        rd_en   = 1'b1;
                        rd_lidx = AW'(1);
                    end
                end
            end
            S_SRCH_RD:
            begin
                if (idx_reg == fill_reg)
                begin
                    pend_tag_next = cmd_tag_reg;
                    pend_ev_next  = frwl_pkg::EV_NOT_FOUND;
                    state_next    = S_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_lidx    = idx_reg[AW-1:0];
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                if (rd_data.tag == cmd_tag_reg)
                begin
                    pend_tag_next = cmd_tag_reg;
                    pend_ev_next  = frwl_pkg::EV_CANCELLED;
                    state_next    = S_SH_RD;
                end
                else
                begin
                    idx_next   = idx_plus;
                    state_next = S_SRCH_RD;
                end
            end
            S_SH_RD:
            begin
                // close the gap one entry at a time
                if (idx_plus < fill_reg)
                begin
                    rd_en      = 1'b1;
                    rd_lidx    = idx_plus[AW-1:0];
                    state_next = S_SH_WR;
                end
                else
                begin
                    fill_next  = fill_reg - FW'(1);
                    state_next = S_FIN;
                end
            end
            S_SH_WR:
            begin
                wr_en      = 1'b1;
                wr_lidx    = idx_reg[AW-1:0];
                idx_next   = idx_plus;
                state_next = S_SH_RD;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_tag_next   = pend_tag_reg;
                    res_ev_next    = pend_ev_reg;
                    res_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lock_reg      <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lock_reg      <= lock_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        cmd_tag_reg  <= cmd_tag_next;
        cmd_mem_reg  <= cmd_mem_next;
        cmd_mode_reg <= cmd_mode_next;
        pend_tag_reg <= pend_tag_next;
        pend_ev_reg  <= pend_ev_next;
        res_tag_reg  <= res_tag_next;
        res_ev_reg   <= res_ev_next;
        res_last_reg <= res_last_next;
    end

    assign cmd_stall  = (state_reg != S_IDLE);
    assign res_valid  = res_valid_reg;
    assign result_tag = res_tag_reg;
    assign event_res  = res_ev_reg;
    assign last       = res_last_reg;

endmodule

[sv/frwl_checker.sv]
// port-level checks for the fifo reader/writer lock, bound to the top level
// depends on frwl_pkg and fifo_reader_writer_lock_defines.svh
`include "fifo_reader_writer_lock_defines.svh"

module frwl_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cmd_valid,
    input logic                            cmd_stall,
    input logic [frwl_pkg::OP_W-1:0]       op,
    input logic                            res_valid,
    input logic                            res_stall,
    input logic [frwl_pkg::TAG_W-1:0]      result_tag,
    input logic [frwl_pkg::EV_W-1:0]       event_res,
    input logic                            last
);

    // a stalled result must hold
    `FRWL_ASSERT_NEXT(a_res_hold, res_valid && res_stall,
        res_valid && $stable(result_tag) && $stable(event_res) && $stable(last))

    // only a release chain produces results that are not last
    `FRWL_ASSERT_NOW(a_chain_events, res_valid && !last,
        event_res == frwl_pkg::EV_RELEASED || event_res == frwl_pkg::EV_GRANTED)

    // while a release chain is open no new command is taken
    `FRWL_ASSERT_NOW(a_chain_busy, res_valid && !last, cmd_stall)

    // a real command keeps the block busy in the next cycle
    `FRWL_ASSERT_NEXT(a_busy_after_cmd,
        cmd_valid && !cmd_stall
            && (op == frwl_pkg::OP_ACQUIRE || op == frwl_pkg::OP_RELEASE
                || op == frwl_pkg::OP_CANCEL),
        cmd_stall)

endmodule

bind fifo_reader_writer_lock frwl_checker u_frwl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .op         (op),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .result_tag (result_tag),
    .event_res  (event_res),
    .last       (last)
);

[tb/fifo_reader_writer_lock_tb.sv]
// self-checking testbench for the fifo reader/writer lock
// depends on frwl_pkg and fifo_reader_writer_lock; a local predictor tracks counts and wait queue
// driver and monitor are clocked processes, stimulus is queued by one initial block
module fifo_reader_writer_lock_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH   = frwl_pkg::DEFAULT_QUEUE_DEPTH;
    localparam int OP_W    = frwl_pkg::OP_W;
    localparam int TAG_W   = frwl_pkg::TAG_W;
    localparam int MEM_W   = frwl_pkg::MEM_W;
    localparam int MODE_W  = frwl_pkg::MODE_W;
    localparam int EV_W    = frwl_pkg::EV_W;
    localparam int COUNT_W = frwl_pkg::COUNT_W;

    localparam logic [OP_W-1:0]   OP_UNUSED  = 2'd3;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ALIAS = 2'd3;

    localparam int     RANDOM_CMDS = 193;
    localparam int     QUIET_FROM  = 100;
    localparam int     QUIET_TO    = 140;
    localparam int     HOLD_AT     = 180;
    localparam int     HOLD_CYCLES = 300;
    localparam int     DRAIN_WAIT  = 12;
    localparam longint CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TAG_W-1:0]  tag;
        logic [MEM_W-1:0]  mem;
        logic [MODE_W-1:0] mode;
    } lock_cmd_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [EV_W-1:0]  ev;
        logic             last;
    } lock_event_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [MODE_W-1:0] mode;
    } holder_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    logic [OP_W-1:0]     op = frwl_pkg::OP_ACQUIRE;
    logic [TAG_W-1:0]    requester_tag = '0;
    logic [MEM_W-1:0]    mem_sel = '0;
    logic [MODE_W-1:0]   access_mode = frwl_pkg::MODE_READ;
    logic                res_valid;
    logic                res_stall = 1'b0;
    logic [TAG_W-1:0]    result_tag;
    logic [EV_W-1:0]     event_res;
    logic                last;

    // predictor state
    logic [COUNT_W-1:0] rd_cnt = '0;
    logic [COUNT_W-1:0] wr_cnt = '0;
    logic [MEM_W-1:0]   owner = '0;
    frwl_pkg::entry_t   waiters[$];

    lock_cmd_t   cmd_backlog[$];
    lock_event_t owed_events[$];

    lock_cmd_t   drv_next;
    lock_event_t want_ev;
    int          gap_left = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          n_sent = 0;
    int          n_results = 0;
    int          n_errors = 0;
    longint      n_cycles = 0;

    fifo_reader_writer_lock #(
        .QUEUE_DEPTH(DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .op(op),
        .requester_tag(requester_tag),
        .mem_sel(mem_sel),
        .access_mode(access_mode),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .result_tag(result_tag),
        .event_res(event_res),
        .last(last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic bit quiet_now();
        return (n_sent >= QUIET_FROM && n_sent < QUIET_TO);
    endfunction

    function automatic int draw_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [MODE_W-1:0] draw_mode();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8)
            return frwl_pkg::MODE_READ;
        else if (r < 11)
            return frwl_pkg::MODE_RW;
        else if (r < 19)
            return MODE_WRITE;
        return MODE_ALIAS;
    endfunction

    // grants the mode against the current counts; write and the spare mode code behave alike
    function automatic bit take_lock(logic [MEM_W-1:0] mem, logic [MODE_W-1:0] mode);
        if (mode == frwl_pkg::MODE_READ)
        begin
            if (wr_cnt != '0)
                return 1'b0;
            if (rd_cnt != frwl_pkg::COUNT_MAX)
                rd_cnt = rd_cnt + COUNT_W'(1);
            return 1'b1;
        end
        if (mode == frwl_pkg::MODE_RW)
        begin
            if (rd_cnt != '0 || wr_cnt != '0)
                return 1'b0;
            owner = mem;
            if (rd_cnt != frwl_pkg::COUNT_MAX)
                rd_cnt = rd_cnt + COUNT_W'(1);
            if (wr_cnt != frwl_pkg::COUNT_MAX)
                wr_cnt = wr_cnt + COUNT_W'(1);
            return 1'b1;
        end
        if (rd_cnt != '0 || (wr_cnt != '0 && owner != mem))
            return 1'b0;
        owner = mem;
        if (wr_cnt != frwl_pkg::COUNT_MAX)
            wr_cnt = wr_cnt + COUNT_W'(1);
        return 1'b1;
    endfunction

    function automatic void owe(logic [TAG_W-1:0] t, logic [EV_W-1:0] e);
        lock_event_t ev;
        ev.tag = t;
        ev.ev = e;
        ev.last = 1'b0;
        owed_events.insert(owed_events.size(), ev);
    endfunction

    // works out every result one accepted command causes
    function automatic void lock_outcome(lock_cmd_t c);
        int               first_new;
        bit               hit;
        frwl_pkg::entry_t ent;
        first_new = owed_events.size();
        hit = 1'b0;
        case (c.op)
            frwl_pkg::OP_ACQUIRE:
            begin
                if (waiters.size() == 0 && take_lock(c.mem, c.mode))
                    owe(c.tag, frwl_pkg::EV_GRANTED);
                else if (waiters.size() < DEPTH)
                begin
                    ent.tag = c.tag;
                    ent.mem = c.mem;
                    ent.mode = c.mode;
                    waiters.insert(waiters.size(), ent);
                    owe(c.tag, frwl_pkg::EV_QUEUED);
                end
                else
                    owe(c.tag, frwl_pkg::EV_FULL);
            end
            frwl_pkg::OP_RELEASE:
            begin
                if ((c.mode == frwl_pkg::MODE_READ || c.mode == frwl_pkg::MODE_RW)
                    && rd_cnt != '0)
                    rd_cnt = rd_cnt - COUNT_W'(1);
                if (c.mode != frwl_pkg::MODE_READ && wr_cnt != '0)
                    wr_cnt = wr_cnt - COUNT_W'(1);
                owe(c.tag, frwl_pkg::EV_RELEASED);
                while (waiters.size() != 0 && take_lock(waiters[0].mem, waiters[0].mode))
                begin
                    owe(waiters[0].tag, frwl_pkg::EV_GRANTED);
                    waiters.delete(0);
                end
            end
            frwl_pkg::OP_CANCEL:
            begin
                // only the oldest waiter with the tag goes
                for (int k = 0; k < waiters.size(); k++)
                begin
                    if (waiters[k].tag == c.tag)
                    begin
                        waiters.delete(k);
                        hit = 1'b1;
                        break;
                    end
                end
                owe(c.tag, hit ? frwl_pkg::EV_CANCELLED : frwl_pkg::EV_NOT_FOUND);
            end
            default: ;
        endcase
        if (owed_events.size() > first_new)
            owed_events[owed_events.size()-1].last = 1'b1;
    endfunction

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            gap_left <= 0;
            n_sent <= 0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                lock_outcome('{op: op, tag: requester_tag, mem: mem_sel, mode: access_mode});
                n_sent <= n_sent + 1;
            end
            if (!cmd_valid || !cmd_stall)
            begin
                if (gap_left != 0)
                begin
                    cmd_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    drv_next = cmd_backlog[0];
                    cmd_backlog.delete(0);
                    cmd_valid <= 1'b1;
                    op <= drv_next.op;
                    requester_tag <= drv_next.tag;
                    mem_sel <= drv_next.mem;
                    access_mode <= drv_next.mode;
                    if (quiet_now() || $urandom_range(0, 1) == 0)
                        gap_left <= 0;
                    else
                        gap_left <= draw_idle_len();
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // result back-pressure, with one long hold-off while commands keep coming
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && n_sent >= HOLD_AT)
        begin
            res_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            res_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (quiet_now())
            res_stall <= 1'b0;
        else if ($urandom_range(0, 99) < 45)
        begin
            res_stall <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end
        else
        begin
            res_stall <= 1'b1;
            stall_left <= draw_idle_len() - 1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (owed_events.size() == 0)
            begin
                $error("unexpected result transfer: result_tag %0h event_res %0d last %0b",
                       result_tag, event_res, last);
                n_errors++;
            end
            else
            begin
                want_ev = owed_events[0];
                owed_events.delete(0);
                if (result_tag !== want_ev.tag)
                begin
                    $error("result_tag mismatch: expected %0h, got %0h", want_ev.tag, result_tag);
                    n_errors++;
                end
                if (event_res !== want_ev.ev)
                begin
                    $error("event_res mismatch (tag %0h): expected %0d, got %0d",
                           want_ev.tag, want_ev.ev, event_res);
                    n_errors++;
                end
                if (last !== want_ev.last)
                begin
                    $error("last mismatch (tag %0h): expected %0b, got %0b",
                           want_ev.tag, want_ev.last, last);
                    n_errors++;
                end
                n_results++;
            end
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     n_cycles, owed_events.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic queue_cmd(logic [OP_W-1:0] o, logic [TAG_W-1:0] t,
                             logic [MEM_W-1:0] m, logic [MODE_W-1:0] md);
        cmd_backlog.insert(cmd_backlog.size(), lock_cmd_t'{op: o, tag: t, mem: m, mode: md});
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_backlog.size() != 0 || cmd_valid || owed_events.size() != 0);
    endtask

    initial
    begin : stimulus
        holder_t         holders[$];
        holder_t         pick;
        int              sel;
        int              idx;
        logic [TAG_W-1:0] t;
        logic [MODE_W-1:0] md;

        // directed: writers share memory 7, then the queue fills up behind them
        queue_cmd(frwl_pkg::OP_ACQUIRE, 8'h00, 3'd7, MODE_WRITE);
        queue_cmd(frwl_pkg::OP_ACQUIRE, 8'h01, 3'd7, MODE_ALIAS);
        queue_cmd(frwl_pkg::OP_ACQUIRE, 8'hFF, 3'd0, frwl_pkg::MODE_READ);
        queue_cmd(frwl_pkg::OP_ACQUIRE, 8'h10, 3'd7, MODE_WRITE);
        queue_cmd(frwl_pkg::OP_ACQUIRE, 8'h10, 3'd3, frwl_pkg::MODE_RW);
        for (int k = 0; k < 13; k++)
            queue_cmd(frwl_pkg::OP_ACQUIRE, TAG_W'(8'h20 + k), MEM_W'(k), frwl_pkg::MODE_READ);
        queue_cmd(frwl_pkg::OP_ACQUIRE, 8'h30, 3'd5, MODE_WRITE);
        // duplicate tag: the older write waiter must be the one removed
        queue_cmd(frwl_pkg::OP_CANCEL, 8'h10, 3'd0, frwl_pkg::MODE_READ);
        queue_cmd(frwl_pkg::OP_CANCEL, 8'h99, 3'd7, MODE_ALIAS);
        queue_cmd(OP_UNUSED, 8'h77, 3'd2, frwl_pkg::MODE_RW);
        queue_cmd(frwl_pkg::OP_RELEASE, 8'h00, 3'd7, MODE_WRITE);
        queue_cmd(frwl_pkg::OP_RELEASE, 8'h01, 3'd7, MODE_ALIAS);
        queue_cmd(frwl_pkg::OP_RELEASE, 8'hFF, 3'd0, frwl_pkg::MODE_READ);
        queue_cmd(frwl_pkg::OP_RELEASE, 8'h10, 3'd3, frwl_pkg::MODE_RW);
        // writer count already zero here, so it clamps
        queue_cmd(frwl_pkg::OP_RELEASE, 8'h55, 3'd1, frwl_pkg::MODE_RW);
        for (int k = 0; k < 12; k++)
            holders.insert(holders.size(),
                           holder_t'{tag: TAG_W'(8'h20 + k), mode: frwl_pkg::MODE_READ});

        // random: mostly acquire/release pairs, some cancels and noise
        for (int k = 0; k < RANDOM_CMDS; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 3)
                queue_cmd(OP_UNUSED, TAG_W'($urandom_range(0, 255)),
                          MEM_W'($urandom_range(0, 7)), MODE_W'($urandom_range(0, 3)));
            else if (sel < 48)
            begin
                t = TAG_W'($urandom_range(0, 255));
                md = draw_mode();
                // bias toward few memories so writers often share
                queue_cmd(frwl_pkg::OP_ACQUIRE, t,
                          MEM_W'($urandom_range(0, 1) ? $urandom_range(0, 1)
                                                      : $urandom_range(0, 7)),
                          md);
                holders.insert(holders.size(), holder_t'{tag: t, mode: md});
            end
            else if (sel < 86)
            begin
                if (holders.size() != 0 && $urandom_range(0, 9) != 0)
                begin
                    idx = $urandom_range(0, holders.size() - 1);
                    pick = holders[idx];
                    holders.delete(idx);
                    queue_cmd(frwl_pkg::OP_RELEASE, pick.tag, MEM_W'($urandom_range(0, 7)),
                              pick.mode);
                end
                else
                    queue_cmd(frwl_pkg::OP_RELEASE, TAG_W'($urandom_range(0, 255)),
                              MEM_W'($urandom_range(0, 7)), draw_mode());
            end
            else
            begin
                if (holders.size() != 0 && $urandom_range(0, 2) != 0)
                begin
                    idx = $urandom_range(0, holders.size() - 1);
                    pick = holders[idx];
                    holders.delete(idx);
                    queue_cmd(frwl_pkg::OP_CANCEL, pick.tag, MEM_W'($urandom_range(0, 7)),
                              MODE_W'($urandom_range(0, 3)));
                end
                else
                    queue_cmd(frwl_pkg::OP_CANCEL, TAG_W'($urandom_range(0, 255)),
                              MEM_W'($urandom_range(0, 7)), MODE_W'($urandom_range(0, 3)));
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d commands transferred, %0d results checked over %0d cycles",
                 n_sent, n_results, n_cycles);
        $display("covered shared writers, full queue, duplicate cancel, clamping and long stalls");
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
